### rtl/core/efd_pkg.sv
// Shared constants and types of the escaped frame deframer.
// No dependencies; used by the interfaces and every module of the block.
package efd_pkg;

  localparam int unsigned MAX_FRAME_LEN = 80;
  localparam int unsigned MIN_FRAME_LEN = 7;

  localparam logic [7:0] CHAR_START  = 8'h3C;
  localparam logic [7:0] CHAR_SEP    = 8'h24;
  localparam logic [7:0] CHAR_END    = 8'h3E;
  localparam logic [7:0] CHAR_ESCAPE = 8'h2F;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_FIVE   = 8'h35;

  localparam logic [2:0] REQ_TYPE_MAX = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CORRUPT  = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_FRAMING  = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } byte_stage_t;

endpackage

### rtl/core/efd_if.sv
// Valid/ready channel interfaces of the escaped frame deframer.
// Depends on efd_pkg.
interface efd_rx_if import efd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface efd_res_if import efd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       frame_done;
  logic [1:0] frame_status;

  modport source(output valid, output data_valid, output data_byte, output frame_done,
                 output frame_status, input ready);
  modport sink(input valid, input data_valid, input data_byte, input frame_done,
               input frame_status, output ready);
endinterface

### rtl/core/efd_in_stage.sv
// Input register of the escaped frame deframer: holds one received byte.
// Depends on efd_pkg and efd_rx_if.
module efd_in_stage import efd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  efd_rx_if.sink        rx_i,
  input  logic          take_i,
  output byte_stage_t   stage_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       load;

  assign load       = !valid_q || take_i;
  assign rx_i.ready = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && rx_i.valid) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  assign stage_o.valid   = valid_q;
  assign stage_o.rx_byte = byte_q;

endmodule

### rtl/core/efd_core.sv
// Frame parser and result register of the escaped frame deframer.
// Depends on efd_pkg and efd_res_if.
module efd_core import efd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  byte_stage_t   stage_i,
  output logic          take_o,
  input  logic          req_type_we_i,
  input  logic [2:0]    req_type_i,
  efd_res_if.source     res_o
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_LEN1     = 3'd1;
  localparam logic [2:0] PH_LEN2     = 3'd2;
  localparam logic [2:0] PH_SEP1     = 3'd3;
  localparam logic [2:0] PH_TYPE     = 3'd4;
  localparam logic [2:0] PH_SEP2_OK  = 3'd5;
  localparam logic [2:0] PH_SEP2_BAD = 3'd6;
  localparam logic [2:0] PH_PAYLOAD  = 3'd7;

  logic [2:0] req_type_q;
  logic [2:0] phase_q, phase_d;
  logic [6:0] frame_length_q, frame_length_d;
  logic [6:0] consumed_q, consumed_d;
  logic [6:0] emitted_q, emitted_d;
  logic [6:0] escapes_q, escapes_d;
  logic       esc_pending_q, esc_pending_d;

  logic       out_valid_q;
  logic       data_valid_q, data_valid_d;
  logic [7:0] data_byte_q, data_byte_d;
  logic       frame_done_q, frame_done_d;
  logic [1:0] status_q, status_d;

  logic       step;
  logic [7:0] b;
  logic       is_digit;
  logic [6:0] dval;
  logic       type_ok;
  logic       len_ok;
  logic [6:0] cons_inc;
  logic [7:0] limit_sum;
  logic [8:0] total;

  assign take_o = !out_valid_q || res_o.ready;
  assign step   = stage_i.valid && take_o;
  assign b      = stage_i.rx_byte;

  assign is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign dval      = {3'b000, b[3:0]};
  assign type_ok   = (req_type_q <= REQ_TYPE_MAX) && (b == (CHAR_FIVE + {5'b00000, req_type_q}));
  assign len_ok    = (frame_length_q >= 7'(MIN_FRAME_LEN)) &&
                     (frame_length_q <= 7'(MAX_FRAME_LEN));
  assign cons_inc  = consumed_q + 7'd1;
  assign limit_sum = {1'b0, cons_inc} + 8'd6;
  assign total     = {2'b00, emitted_q} + {2'b00, escapes_q} + 9'(MIN_FRAME_LEN);

  always_comb begin
    phase_d        = phase_q;
    frame_length_d = frame_length_q;
    consumed_d     = consumed_q;
    emitted_d      = emitted_q;
    escapes_d      = escapes_q;
    esc_pending_d  = esc_pending_q;
    data_valid_d   = 1'b0;
    data_byte_d    = 8'h00;
    frame_done_d   = 1'b0;
    status_d       = ST_OK;

    unique case (phase_q)
      PH_IDLE: begin
        if (b == CHAR_START) begin
          frame_length_d = 7'd0;
          consumed_d     = 7'd0;
          emitted_d      = 7'd0;
          escapes_d      = 7'd0;
          esc_pending_d  = 1'b0;
          phase_d        = PH_LEN1;
        end
      end
      PH_LEN1: begin
        if (is_digit) begin
          frame_length_d = (dval << 3) + (dval << 1);
          phase_d        = PH_LEN2;
        end else begin
          frame_done_d = 1'b1;
          status_d     = ST_FRAMING;
          phase_d      = PH_IDLE;
        end
      end
      PH_LEN2: begin
        if (is_digit) begin
          frame_length_d = frame_length_q + dval;
          phase_d        = PH_SEP1;
        end else begin
          frame_done_d = 1'b1;
          status_d     = ST_FRAMING;
          phase_d      = PH_IDLE;
        end
      end
      PH_SEP1: begin
        if (b != CHAR_SEP || !len_ok) begin
          frame_done_d = 1'b1;
          status_d     = ST_FRAMING;
          phase_d      = PH_IDLE;
        end else begin
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        phase_d = type_ok ? PH_SEP2_OK : PH_SEP2_BAD;
      end
      PH_SEP2_OK, PH_SEP2_BAD: begin
        if (b != CHAR_SEP) begin
          frame_done_d = 1'b1;
          status_d     = ST_FRAMING;
          phase_d      = PH_IDLE;
        end else if (phase_q == PH_SEP2_BAD) begin
          frame_done_d = 1'b1;
          status_d     = ST_MISMATCH;
          phase_d      = PH_IDLE;
        end else begin
          consumed_d    = 7'd0;
          emitted_d     = 7'd0;
          escapes_d     = 7'd0;
          esc_pending_d = 1'b0;
          phase_d       = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        consumed_d = cons_inc;
        if (b == CHAR_END && !esc_pending_q) begin
          frame_done_d = 1'b1;
          status_d     = (total == {2'b00, frame_length_q}) ? ST_OK : ST_CORRUPT;
          phase_d      = PH_IDLE;
        end else begin
          if (b == CHAR_END) begin
            data_valid_d  = 1'b1;
            data_byte_d   = b;
            esc_pending_d = 1'b0;
            escapes_d     = escapes_q + 7'd1;
            emitted_d     = emitted_q + 7'd1;
          end else if (b == CHAR_ESCAPE) begin
            esc_pending_d = 1'b1;
          end else begin
            data_valid_d = 1'b1;
            data_byte_d  = b;
            emitted_d    = emitted_q + 7'd1;
          end
          if (limit_sum >= {1'b0, frame_length_q}) begin
            frame_done_d = 1'b1;
            status_d     = ST_CORRUPT;
            phase_d      = PH_IDLE;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_type_q <= 3'd0;
    end else if (req_type_we_i) begin
      req_type_q <= req_type_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      frame_length_q <= 7'd0;
      consumed_q     <= 7'd0;
      emitted_q      <= 7'd0;
      escapes_q      <= 7'd0;
      esc_pending_q  <= 1'b0;
    end else if (step) begin
      phase_q        <= phase_d;
      frame_length_q <= frame_length_d;
      consumed_q     <= consumed_d;
      emitted_q      <= emitted_d;
      escapes_q      <= escapes_d;
      esc_pending_q  <= esc_pending_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      data_valid_q <= data_valid_d;
      data_byte_q  <= data_byte_d;
      frame_done_q <= frame_done_d;
      status_q     <= status_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.data_valid   = data_valid_q;
  assign res_o.data_byte    = data_byte_q;
  assign res_o.frame_done   = frame_done_q;
  assign res_o.frame_status = status_q;

  a_len_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> frame_length_q >= 7'(MIN_FRAME_LEN) &&
                              frame_length_q <= 7'(MAX_FRAME_LEN))
    else $error("payload phase with frame length out of range");

  a_limit_not_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> ({1'b0, consumed_q} + 8'd6) < {1'b0, frame_length_q})
    else $error("payload phase past its length limit");

  a_ok_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && frame_done_q && status_q == ST_OK |-> !data_valid_q)
    else $error("ok frame end carries a data byte");

  a_status_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !frame_done_q |-> status_q == ST_OK)
    else $error("status set without frame end");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !data_valid_q |-> data_byte_q == 8'h00)
    else $error("data byte set without data valid");

endmodule

### rtl/core/escaped_frame_deframer.sv
// Top level of the escaped frame deframer.
// Depends on efd_pkg, efd_rx_if, efd_res_if, efd_in_stage and efd_core.
//
// Usage:
//   rx_i carries received bytes (rx_byte) on a valid/ready channel; res_o
//   returns exactly one result per byte: data_valid/data_byte for payload
//   bytes, frame_done/frame_status when the byte ends or aborts a frame.
//   req_type_we_i/req_type_i load the request code (0..4); write it only
//   while no transfer is in flight.
// Path: a byte is taken into the input register, and its result is loaded
//   into the result register when the parser steps, which res_o can stall.
// Throughput: one byte per cycle while res_o.ready is high; the parser step
//   between the input register and the result register is combinational.
// Reset: rst_ni (async, active low) returns the parser to waiting for '<',
//   clears the request code and empties both registers.
// Stall: when res_o.ready is low the result register holds and the input
//   register takes one more byte; rx_i.ready then drops until the result
//   is transferred.
module escaped_frame_deframer import efd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  efd_rx_if.sink     rx_i,
  efd_res_if.source  res_o,
  input  logic       req_type_we_i,
  input  logic [2:0] req_type_i
);

  byte_stage_t stage;
  logic        take;

  efd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .take_i  (take),
    .stage_o (stage)
  );

  efd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_i       (stage),
    .take_o        (take),
    .req_type_we_i (req_type_we_i),
    .req_type_i    (req_type_i),
    .res_o         (res_o)
  );

endmodule

### verif/testbench.sv
// Self-checking testbench for escaped_frame_deframer: streams framed byte traffic
// through the rx channel and checks every result against a cycle-free predictor.
// Depends on efd_pkg, efd_rx_if, efd_res_if and the escaped_frame_deframer RTL.
module testbench import efd_pkg::*; ();

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD = 120;

  typedef enum logic [2:0] {
    P_IDLE, P_LEN_HI, P_LEN_LO, P_SEP1, P_TYPE, P_SEP2_MATCH, P_SEP2_WRONG, P_PAYLOAD
  } parse_phase_e;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       frame_done;
    logic [1:0] frame_status;
  } deframe_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic req_type_we_i;
  logic [2:0] req_type_i;

  efd_rx_if  rx_ch ();
  efd_res_if res_ch ();

  escaped_frame_deframer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_i          (rx_ch),
    .res_o         (res_ch),
    .req_type_we_i (req_type_we_i),
    .req_type_i    (req_type_i)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state
  parse_phase_e parse_phase = P_IDLE;
  logic [2:0] req_code = '0;
  logic [6:0] frame_len = '0;
  logic [6:0] payload_consumed = '0;
  logic [6:0] payload_emitted = '0;
  logic [6:0] escapes_seen = '0;
  logic       escape_pending = 1'b0;

  logic [7:0]      rx_stream[$];
  deframe_result_t predicted_outputs[$];
  int unsigned     bytes_queued = 0;
  int unsigned     mismatches = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     tx_gap_left;
  int unsigned     rx_stall_left;
  int unsigned     hold_requests;
  int unsigned     holds_served;
  bit              tx_gaps_on;
  bit              rx_gaps_on;

  function automatic void close_frame(inout deframe_result_t r, input logic [1:0] status);
    r.frame_done = 1'b1;
    r.frame_status = status;
    parse_phase = P_IDLE;
  endfunction

  function automatic deframe_result_t deframe_byte(input logic [7:0] b);
    deframe_result_t r;
    logic is_digit;
    logic ended;
    r = '0;
    ended = 1'b0;
    is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    case (parse_phase)
      P_IDLE: begin
        if (b == CHAR_START) begin
          frame_len = '0;
          payload_consumed = '0;
          payload_emitted = '0;
          escapes_seen = '0;
          escape_pending = 1'b0;
          parse_phase = P_LEN_HI;
        end
      end
      P_LEN_HI: begin
        if (is_digit) begin
          frame_len = 7'((b - CHAR_ZERO) * 8'd10);
          parse_phase = P_LEN_LO;
        end else begin
          close_frame(r, ST_FRAMING);
        end
      end
      P_LEN_LO: begin
        if (is_digit) begin
          frame_len = frame_len + 7'(b - CHAR_ZERO);
          parse_phase = P_SEP1;
        end else begin
          close_frame(r, ST_FRAMING);
        end
      end
      P_SEP1: begin
        if (b != CHAR_SEP || frame_len < MIN_FRAME_LEN || frame_len > MAX_FRAME_LEN)
          close_frame(r, ST_FRAMING);
        else
          parse_phase = P_TYPE;
      end
      P_TYPE: begin
        if (req_code <= REQ_TYPE_MAX && b == CHAR_FIVE + 8'(req_code))
          parse_phase = P_SEP2_MATCH;
        else
          parse_phase = P_SEP2_WRONG;
      end
      P_SEP2_MATCH, P_SEP2_WRONG: begin
        if (b != CHAR_SEP) begin
          close_frame(r, ST_FRAMING);
        end else if (parse_phase == P_SEP2_WRONG) begin
          close_frame(r, ST_MISMATCH);
        end else begin
          payload_consumed = '0;
          payload_emitted = '0;
          escapes_seen = '0;
          escape_pending = 1'b0;
          parse_phase = P_PAYLOAD;
        end
      end
      default: begin
        payload_consumed = payload_consumed + 7'd1;
        if (b == CHAR_END) begin
          if (escape_pending) begin
            r.data_valid = 1'b1;
            r.data_byte = b;
            escape_pending = 1'b0;
            escapes_seen = escapes_seen + 7'd1;
            payload_emitted = payload_emitted + 7'd1;
          end else begin
            ended = 1'b1;
          end
        end else if (b == CHAR_ESCAPE) begin
          escape_pending = 1'b1;
        end else begin
          r.data_valid = 1'b1;
          r.data_byte = b;
          payload_emitted = payload_emitted + 7'd1;
        end
        if (ended)
          close_frame(r, (int'(payload_emitted) + int'(escapes_seen) + 7 == int'(frame_len))
                         ? ST_OK : ST_CORRUPT);
        else if (int'(payload_consumed) + 6 >= int'(frame_len))
          close_frame(r, ST_CORRUPT);
      end
    endcase
    return r;
  endfunction

  function automatic int unsigned next_gap(input bit enabled);
    int unsigned pick;
    if (!enabled) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    rx_stream.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  task automatic queue_maybe_garbled(input logic [7:0] b);
    if ($urandom_range(0, 99) < 3) queue_byte(8'($urandom_range(0, 255)));
    else queue_byte(b);
  endtask

  task automatic queue_random_frame();
    int unsigned len;
    int unsigned budget;
    int unsigned pick;
    logic [7:0] b;
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (pick < 80) len = $urandom_range(MIN_FRAME_LEN, 16);
    else if (pick < 90) len = $urandom_range(17, MAX_FRAME_LEN);
    else len = $urandom_range(0, 99);
    queue_byte(CHAR_START);
    queue_maybe_garbled(CHAR_ZERO + 8'(len / 10));
    queue_maybe_garbled(CHAR_ZERO + 8'(len % 10));
    queue_maybe_garbled(CHAR_SEP);
    pick = $urandom_range(0, 99);
    if (req_code <= REQ_TYPE_MAX && pick < 85) queue_byte(CHAR_FIVE + 8'(req_code));
    else if (pick < 95) queue_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
    else queue_byte(8'($urandom_range(0, 255)));
    queue_maybe_garbled(CHAR_SEP);
    budget = (len >= MIN_FRAME_LEN) ? len - MIN_FRAME_LEN : 0;
    while (budget != 0) begin
      pick = $urandom_range(0, 99);
      if (pick >= 70 && pick < 85 && budget >= 2) begin
        queue_byte(CHAR_ESCAPE);
        queue_byte(CHAR_END);
        budget -= 2;
      end else if (pick >= 85 && pick < 90) begin
        queue_byte(CHAR_ESCAPE);
        budget--;
      end else if (pick >= 90 && pick < 95) begin
        queue_byte(8'($urandom_range(0, 255)));
        budget--;
      end else if (pick >= 95) begin
        queue_byte(CHAR_START);
        budget--;
      end else begin
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_END || b == CHAR_ESCAPE);
        queue_byte(b);
        budget--;
      end
    end
    if ($urandom_range(0, 99) < 88) queue_byte(CHAR_END);
  endtask

  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (rx_stream.size() != 0 || rx_ch.valid || predicted_outputs.size() != 0);
  endtask

  task automatic write_request_type(input logic [2:0] code);
    @(posedge clk_i);
    req_type_we_i <= 1'b1;
    req_type_i <= code;
    req_code = code;
    @(posedge clk_i);
    req_type_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Driver: offer one pending byte per transfer, with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_ch.valid <= 1'b0;
      tx_gap_left <= 0;
    end else begin
      if (rx_ch.valid && rx_ch.ready)
        predicted_outputs.push_back(deframe_byte(rx_ch.rx_byte));
      if (!rx_ch.valid || rx_ch.ready) begin
        if (tx_gap_left != 0) begin
          tx_gap_left <= tx_gap_left - 1;
          rx_ch.valid <= 1'b0;
        end else if (rx_stream.size() != 0) begin
          rx_ch.valid <= 1'b1;
          rx_ch.rx_byte <= rx_stream.pop_front();
          tx_gap_left <= next_gap(tx_gaps_on);
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer and drive ready with random stalls
  always @(posedge clk_i) begin : result_monitor
    deframe_result_t want;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      rx_stall_left <= 0;
      holds_served <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (predicted_outputs.size() == 0) begin
          $display("%0t: unexpected result dv=%0b byte=%02h done=%0b status=%0d", $time,
                   res_ch.data_valid, res_ch.data_byte, res_ch.frame_done,
                   res_ch.frame_status);
          mismatches++;
        end else begin
          want = predicted_outputs.pop_front();
          if (res_ch.data_valid !== want.data_valid || res_ch.data_byte !== want.data_byte ||
              res_ch.frame_done !== want.frame_done ||
              res_ch.frame_status !== want.frame_status) begin
            $display("%0t: mismatch expected dv=%0b byte=%02h done=%0b status=%0d",
                     $time, want.data_valid, want.data_byte, want.frame_done,
                     want.frame_status);
            $display("%0t:          actual   dv=%0b byte=%02h done=%0b status=%0d",
                     $time, res_ch.data_valid, res_ch.data_byte, res_ch.frame_done,
                     res_ch.frame_status);
            mismatches++;
          end
        end
      end
      if (holds_served != hold_requests) begin
        holds_served <= hold_requests;
        rx_stall_left <= LONG_HOLD;
        res_ch.ready <= 1'b0;
      end else if (rx_stall_left != 0) begin
        rx_stall_left <= rx_stall_left - 1;
        res_ch.ready <= 1'b0;
      end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
        rx_stall_left <= next_gap(1'b1);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [2:0] codes [7];
    int unsigned stop_at;
    codes = '{3'd7, 3'd4, 3'd2, 3'd5, 3'd1, 3'd3, 3'd0};
    rst_ni = 1'b0;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready = 1'b0;
    req_type_we_i = 1'b0;
    req_type_i = '0;
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    hold_requests = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_request_type(3'd0);
    queue_byte(CHAR_START);
    queue_byte(8'h00);
    queue_text("<99$");
    queue_text("<08$5$<>");
    queue_text("<08$5$/>");
    queue_byte(8'hFF);
    wait_for_drain();

    foreach (codes[i]) begin
      write_request_type(codes[i]);
      tx_gaps_on = (i != 1) && (i != 2);
      rx_gaps_on = (i != 1);
      if (i == 0) queue_text("<07$5$>");
      if (i == 2) hold_requests++;
      stop_at = bytes_queued + 90;
      while (bytes_queued < stop_at) queue_random_frame();
      wait_for_drain();
    end

    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && predicted_outputs.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/core/efd_pkg.sv
rtl/core/efd_if.sv
rtl/core/efd_in_stage.sv
rtl/core/efd_core.sv
rtl/core/escaped_frame_deframer.sv
verif/testbench.sv
